/* sv/nec_ir_pkg.sv */
// Shared types, constants and helpers for the NEC IR frame decoder.
package nec_ir_pkg;

   localparam int unsigned COUNTER_BITS  = 16;
   localparam int unsigned FRAME_BITS    = 32;
   localparam int unsigned STAMP_BITS    = 32;
   localparam int unsigned REG_BITS      = 16;
   localparam int unsigned NUM_REGS      = 8;
   localparam int unsigned COUNT_BITS    = 6;
   localparam int unsigned BIT_IDX_BITS  = $clog2(FRAME_BITS);
   localparam logic [STAMP_BITS-1:0] TIMEOUT_TICKS = STAMP_BITS'(20000);
   localparam logic [STAMP_BITS-1:0] CAPTURE_MASK  =
      STAMP_BITS'((64'd1 << COUNTER_BITS) - 64'd1);

   typedef enum logic [1:0] {
      REQ_TICK = 2'd0,
      REQ_EDGE = 2'd1,
      REQ_READ = 2'd2
   } req_kind_type;

   typedef enum logic [2:0] {
      REG_LEAD_LOW    = 3'd0,
      REG_LEAD_HIGH   = 3'd1,
      REG_REPEAT_LOW  = 3'd2,
      REG_REPEAT_HIGH = 3'd3,
      REG_ONE_LOW     = 3'd4,
      REG_ONE_HIGH    = 3'd5,
      REG_ZERO_LOW    = 3'd6,
      REG_ZERO_HIGH   = 3'd7
   } reg_index_type;

   typedef logic [REG_BITS-1:0] reg_file_type [NUM_REGS];

   function automatic logic [REG_BITS-1:0] reg_reset_value(input logic [2:0] idx);
      logic [REG_BITS-1:0] v;
      unique case (idx)
         REG_LEAD_LOW:    v = 16'd13000;
         REG_LEAD_HIGH:   v = 16'd14000;
         REG_REPEAT_LOW:  v = 16'd11000;
         REG_REPEAT_HIGH: v = 16'd12000;
         REG_ONE_LOW:     v = 16'd2000;
         REG_ONE_HIGH:    v = 16'd2500;
         REG_ZERO_LOW:    v = 16'd1000;
         REG_ZERO_HIGH:   v = 16'd1300;
         default:         v = '0;
      endcase
      return v;
   endfunction

   // strict window test on a gap against two 16-bit bounds
   function automatic logic in_window(input logic [STAMP_BITS-1:0] gap,
                                      input logic [REG_BITS-1:0]   lo,
                                      input logic [REG_BITS-1:0]   hi);
      return (gap > STAMP_BITS'(lo)) && (gap < STAMP_BITS'(hi));
   endfunction

endpackage

/* sv/nec_ir_frame_decoder.sv */
// NEC IR frame decoder top level: event register, state update, result register.
// Takes one word per cycle (tick, falling-edge capture or key read) and updates the
// decoder state in a single pass; a key read yields its result word via the event
// register into an output register, held there so new words keep flowing while it waits.
// Sustained rate is one word per clock, set by the single state-update stage; only a
// key read that meets a full, stalled output register holds up the input side.
module nec_ir_frame_decoder (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_type,
   input  logic [15:0] req_capture_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_key_valid,
   output logic [7:0]  rsp_key_code,
   output logic [31:0] rsp_frame_word,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int unsigned SB = nec_ir_pkg::STAMP_BITS;
   localparam int unsigned CB = nec_ir_pkg::COUNT_BITS;

   nec_ir_pkg::reg_file_type cfg_ff;

   // event register
   logic        s1_valid_ff;
   logic [1:0]  s1_type_ff;
   logic [15:0] s1_capture_ff;

   // decoder state
   logic                             receiving_ff, receiving_in;
   logic [CB-1:0]                    bit_count_ff, bit_count_in;
   logic [SB-1:0]                    last_stamp_ff, last_stamp_in;
   logic [15:0]                      overflow_count_ff, overflow_count_in;
   logic [nec_ir_pkg::FRAME_BITS-1:0] received_word_ff, received_word_in;
   logic                             frame_ready_ff, frame_ready_in;
   logic                             repeat_seen_ff, repeat_seen_in;

   // result register
   logic        rsp_valid_ff;
   logic        rsp_key_valid_ff, rsp_key_valid_in;
   logic [7:0]  rsp_key_code_ff, rsp_key_code_in;
   logic [31:0] rsp_frame_word_ff, rsp_frame_word_in;

   logic          s1_is_read;
   logic          s1_go;
   logic          rsp_load;
   logic [15:0]   ovf_inc;
   logic [SB-1:0] now_stamp;
   logic [SB-1:0] gap;
   logic [SB-1:0] elapsed;
   logic [CB-1:0] count_inc;
   logic          key_pending;

   assign s1_is_read = (s1_type_ff == nec_ir_pkg::REQ_READ);
   // a read may only move on when the result register is free or draining
   assign s1_go      = s1_valid_ff && (!s1_is_read || !rsp_valid_ff || rsp_ready);
   assign req_ready  = !s1_valid_ff || s1_go;
   assign rsp_load   = s1_go && s1_is_read;

   assign ovf_inc   = overflow_count_ff + 16'd1;
   assign now_stamp = (SB'(overflow_count_ff) << nec_ir_pkg::COUNTER_BITS)
                      | (SB'(s1_capture_ff) & nec_ir_pkg::CAPTURE_MASK);
   assign gap       = now_stamp - last_stamp_ff;
   assign elapsed   = (SB'(ovf_inc) << nec_ir_pkg::COUNTER_BITS) - last_stamp_ff;
   assign count_inc = bit_count_ff + CB'(1);
   assign key_pending = frame_ready_ff || repeat_seen_ff;

   always_comb begin
      receiving_in      = receiving_ff;
      bit_count_in      = bit_count_ff;
      last_stamp_in     = last_stamp_ff;
      overflow_count_in = overflow_count_ff;
      received_word_in  = received_word_ff;
      frame_ready_in    = frame_ready_ff;
      repeat_seen_in    = repeat_seen_ff;
      rsp_key_valid_in  = key_pending;
      rsp_key_code_in   = key_pending ? received_word_ff[23:16] : 8'd0;
      rsp_frame_word_in = key_pending ? received_word_ff : '0;

      if (s1_go) begin
         case (s1_type_ff)
            nec_ir_pkg::REQ_TICK: begin
               overflow_count_in = ovf_inc;
               if (receiving_ff && (elapsed > nec_ir_pkg::TIMEOUT_TICKS)) begin
                  receiving_in      = 1'b0;
                  bit_count_in      = '0;
                  overflow_count_in = '0;
                  last_stamp_in     = '0;
               end
            end
            nec_ir_pkg::REQ_EDGE: begin
               last_stamp_in = now_stamp;
               if (!receiving_ff) begin
                  if (nec_ir_pkg::in_window(gap, cfg_ff[nec_ir_pkg::REG_LEAD_LOW],
                                            cfg_ff[nec_ir_pkg::REG_LEAD_HIGH])) begin
                     receiving_in     = 1'b1;
                     bit_count_in     = '0;
                     received_word_in = '0;
                  end else if (nec_ir_pkg::in_window(gap,
                                  cfg_ff[nec_ir_pkg::REG_REPEAT_LOW],
                                  cfg_ff[nec_ir_pkg::REG_REPEAT_HIGH])) begin
                     repeat_seen_in    = 1'b1;
                     overflow_count_in = '0;
                     last_stamp_in     = '0;
                  end
               end else begin
                  if (nec_ir_pkg::in_window(gap, cfg_ff[nec_ir_pkg::REG_ONE_LOW],
                                            cfg_ff[nec_ir_pkg::REG_ONE_HIGH])) begin
                     received_word_in[bit_count_ff[nec_ir_pkg::BIT_IDX_BITS-1:0]] = 1'b1;
                     bit_count_in = count_inc;
                  end else if (nec_ir_pkg::in_window(gap,
                                  cfg_ff[nec_ir_pkg::REG_ZERO_LOW],
                                  cfg_ff[nec_ir_pkg::REG_ZERO_HIGH])) begin
                     bit_count_in = count_inc;
                  end else begin
                     // bad gap: abort, partial word stays
                     receiving_in = 1'b0;
                     bit_count_in = '0;
                  end
                  if (receiving_in && (bit_count_in >= CB'(nec_ir_pkg::FRAME_BITS))) begin
                     frame_ready_in    = 1'b1;
                     receiving_in      = 1'b0;
                     bit_count_in      = '0;
                     overflow_count_in = '0;
                     last_stamp_in     = '0;
                  end
               end
            end
            nec_ir_pkg::REQ_READ: begin
               if (frame_ready_ff) begin
                  frame_ready_in = 1'b0;
               end else if (repeat_seen_ff) begin
                  repeat_seen_in = 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < nec_ir_pkg::NUM_REGS; i++) begin
            cfg_ff[i] <= nec_ir_pkg::reg_reset_value(3'(i));
         end
      end else if (csr_write_en) begin
         cfg_ff[csr_index] <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff       <= 1'b0;
         rsp_valid_ff      <= 1'b0;
         receiving_ff      <= 1'b0;
         bit_count_ff      <= '0;
         last_stamp_ff     <= '0;
         overflow_count_ff <= '0;
         received_word_ff  <= '0;
         frame_ready_ff    <= 1'b0;
         repeat_seen_ff    <= 1'b0;
      end else begin
         if (req_ready) begin
            s1_valid_ff <= req_valid;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         receiving_ff      <= receiving_in;
         bit_count_ff      <= bit_count_in;
         last_stamp_ff     <= last_stamp_in;
         overflow_count_ff <= overflow_count_in;
         received_word_ff  <= received_word_in;
         frame_ready_ff    <= frame_ready_in;
         repeat_seen_ff    <= repeat_seen_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_type_ff    <= req_type;
         s1_capture_ff <= req_capture_value;
      end
      if (rsp_load) begin
         rsp_key_valid_ff  <= rsp_key_valid_in;
         rsp_key_code_ff   <= rsp_key_code_in;
         rsp_frame_word_ff <= rsp_frame_word_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_key_valid  = rsp_key_valid_ff;
   assign rsp_key_code   = rsp_key_code_ff;
   assign rsp_frame_word = rsp_frame_word_ff;

endmodule

/* sim/testbench.sv */
// Testbench for nec_ir_frame_decoder: directed plan, random IR frames, scoreboard on key reads.
module testbench;

   localparam logic [1:0] REQ_UNUSED = 2'd3;

   typedef struct packed {
      logic        key_valid;
      logic [7:0]  key_code;
      logic [31:0] frame_word;
   } key_report_type;

   localparam key_report_type NO_KEY = '0;

   typedef struct packed {
      logic [1:0]     kind;
      logic [15:0]    cap;
      logic           typed;
      key_report_type rpt;
   } plan_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_type;
   logic [15:0] req_capture_value;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   logic        rsp_key_valid;
   logic [7:0]  rsp_key_code;
   logic [31:0] rsp_frame_word;
   logic        csr_write_en;
   logic [2:0]  csr_index;
   logic [15:0] csr_data;

   // decoder shadow state
   nec_ir_pkg::reg_file_type win;
   logic        rx_active;
   logic [5:0]  rx_bits;
   logic [31:0] prev_stamp;
   logic [15:0] ovf_cnt;
   logic [31:0] rx_word;
   logic        frame_pending;
   logic        repeat_pending;

   key_report_type pending_reports [$];
   int  sent_count = 0;
   int  read_count = 0;
   int  key_words_seen = 0;
   int  mismatch_count = 0;
   int  stall_left = 0;
   bit  quiet_tail = 1'b0;

   // reset windows: leader 13000..14000, repeat 11000..12000, one 2000..2500, zero 1000..1300
   plan_row_type dir_plan [23] = '{
      '{nec_ir_pkg::REQ_READ, 16'd0,     1'b1, NO_KEY},
      '{REQ_UNUSED,           16'hFFFF,  1'b0, NO_KEY},
      '{nec_ir_pkg::REQ_EDGE, 16'd13500, 1'b0, NO_KEY},
      '{nec_ir_pkg::REQ_READ, 16'h5A5A,  1'b1, NO_KEY},
      '{nec_ir_pkg::REQ_EDGE, 16'd15750, 1'b0, NO_KEY},
      '{nec_ir_pkg::REQ_EDGE, 16'd16870, 1'b0, NO_KEY},
      '{nec_ir_pkg::REQ_READ, 16'd0,     1'b1, NO_KEY},
      '{nec_ir_pkg::REQ_EDGE, 16'd21870, 1'b0, NO_KEY},
      '{nec_ir_pkg::REQ_EDGE, 16'd33370, 1'b0, NO_KEY},
      '{nec_ir_pkg::REQ_READ, 16'd0,     1'b1, '{1'b1, 8'h00, 32'h0000_0001}},
      '{nec_ir_pkg::REQ_READ, 16'd0,     1'b1, NO_KEY},
      '{nec_ir_pkg::REQ_EDGE, 16'd13001, 1'b0, NO_KEY},
      '{nec_ir_pkg::REQ_TICK, 16'hFFFF,  1'b0, NO_KEY},
      '{nec_ir_pkg::REQ_EDGE, 16'd13000, 1'b0, NO_KEY},
      '{nec_ir_pkg::REQ_EDGE, 16'd26999, 1'b0, NO_KEY},
      '{nec_ir_pkg::REQ_EDGE, 16'd28999, 1'b0, NO_KEY},
      '{nec_ir_pkg::REQ_EDGE, 16'd39999, 1'b0, NO_KEY},
      '{nec_ir_pkg::REQ_EDGE, 16'd51998, 1'b0, NO_KEY},
      '{nec_ir_pkg::REQ_READ, 16'd0,     1'b1, '{1'b1, 8'h00, 32'h0000_0000}},
      '{nec_ir_pkg::REQ_EDGE, 16'd65535, 1'b0, NO_KEY},
      '{nec_ir_pkg::REQ_TICK, 16'd0,     1'b0, NO_KEY},
      '{nec_ir_pkg::REQ_EDGE, 16'd0,     1'b0, NO_KEY},
      '{nec_ir_pkg::REQ_READ, 16'd0,     1'b1, NO_KEY}
   };

   nec_ir_frame_decoder dut (.*);

   always #5 clock = ~clock;

   function automatic bit gap_fits(input logic [31:0] gap,
                                   input nec_ir_pkg::reg_index_type lo_i,
                                   input nec_ir_pkg::reg_index_type hi_i);
      return gap > 32'(win[lo_i]) && gap < 32'(win[hi_i]);
   endfunction

   // applies one word to the shadow decoder; returns 1 when a key word is due
   function automatic bit advance_decoder(input logic [1:0] kind, input logic [15:0] cap,
                                          output key_report_type rpt);
      logic [31:0] stamp;
      logic [31:0] gap;
      bit          hit;
      rpt = NO_KEY;
      hit = 1'b0;
      case (kind)
         nec_ir_pkg::REQ_TICK: begin
            ovf_cnt = ovf_cnt + 16'd1;
            if (rx_active &&
                ((32'(ovf_cnt) << nec_ir_pkg::COUNTER_BITS) - prev_stamp) >
                nec_ir_pkg::TIMEOUT_TICKS) begin
               rx_active = 1'b0;
               rx_bits = '0;
               ovf_cnt = '0;
               prev_stamp = '0;
            end
            return 1'b0;
         end
         nec_ir_pkg::REQ_EDGE: begin
            stamp = (32'(ovf_cnt) << nec_ir_pkg::COUNTER_BITS) |
                    (32'(cap) & nec_ir_pkg::CAPTURE_MASK);
            gap = stamp - prev_stamp;
            prev_stamp = stamp;
            if (!rx_active) begin
               if (gap_fits(gap, nec_ir_pkg::REG_LEAD_LOW, nec_ir_pkg::REG_LEAD_HIGH)) begin
                  rx_active = 1'b1;
                  rx_bits = '0;
                  rx_word = '0;
               end else if (gap_fits(gap, nec_ir_pkg::REG_REPEAT_LOW,
                                     nec_ir_pkg::REG_REPEAT_HIGH)) begin
                  repeat_pending = 1'b1;
                  ovf_cnt = '0;
                  prev_stamp = '0;
               end
               return 1'b0;
            end
            if (gap_fits(gap, nec_ir_pkg::REG_ONE_LOW, nec_ir_pkg::REG_ONE_HIGH)) begin
               rx_word[rx_bits[4:0]] = 1'b1;
               rx_bits = rx_bits + 6'd1;
            end else if (gap_fits(gap, nec_ir_pkg::REG_ZERO_LOW, nec_ir_pkg::REG_ZERO_HIGH)) begin
               rx_bits = rx_bits + 6'd1;
            end else begin
               // abort keeps the partial word
               rx_active = 1'b0;
               rx_bits = '0;
            end
            if (rx_bits >= nec_ir_pkg::FRAME_BITS) begin
               frame_pending = 1'b1;
               rx_active = 1'b0;
               rx_bits = '0;
               ovf_cnt = '0;
               prev_stamp = '0;
            end
            return 1'b0;
         end
         nec_ir_pkg::REQ_READ: begin
            if (frame_pending) begin
               frame_pending = 1'b0;
               hit = 1'b1;
            end else if (repeat_pending) begin
               repeat_pending = 1'b0;
               hit = 1'b1;
            end
            if (hit) begin
               rpt.key_valid = 1'b1;
               rpt.key_code = rx_word[23:16];
               rpt.frame_word = rx_word;
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   task automatic send_word(input logic [1:0] kind, input logic [15:0] cap, input bit typed,
                            input key_report_type typed_rpt);
      key_report_type rpt;
      req_valid <= 1'b1;
      req_type <= kind;
      req_capture_value <= cap;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (advance_decoder(kind, cap, rpt)) pending_reports.push_back(typed ? typed_rpt : rpt);
      sent_count++;
      if (kind == nec_ir_pkg::REQ_READ) read_count++;
      if (!quiet_tail && $urandom_range(5, 0) == 0) begin
         req_valid <= 1'b0;
         req_type <= 2'($urandom);
         req_capture_value <= 16'($urandom);
         repeat ($urandom_range(13, 1)) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] window_gap(input nec_ir_pkg::reg_index_type lo_i,
                                              input nec_ir_pkg::reg_index_type hi_i);
      int unsigned lo;
      int unsigned hi;
      int unsigned top;
      lo = 32'(win[lo_i]);
      hi = 32'(win[hi_i]);
      if (hi <= lo + 1) return $urandom_range(20000, 0);
      top = (hi - 1 > lo + 3000) ? lo + 3000 : hi - 1;
      return $urandom_range(top, lo + 1);
   endfunction

   // falling edge a given gap after the last one; overflow ticks first when the stamp crosses
   task automatic edge_at_gap(input logic [31:0] gap);
      logic [31:0] target;
      logic [15:0] ahead;
      forever begin
         target = prev_stamp + gap;
         ahead = target[31:16] - ovf_cnt;
         if (ahead == 16'd0 || ahead > 16'd3) break;
         send_word(nec_ir_pkg::REQ_TICK, 16'($urandom), 1'b0, NO_KEY);
      end
      send_word(nec_ir_pkg::REQ_EDGE, target[15:0], 1'b0, NO_KEY);
   endtask

   task automatic send_frame(input bit spoil);
      logic [31:0] bits;
      logic [7:0]  addr;
      logic [7:0]  cmd;
      int          bad_at;
      int          i;
      bit          by_tick;
      addr = 8'($urandom);
      cmd = 8'($urandom);
      bits = $urandom_range(1, 0) ? {~cmd, cmd, ~addr, addr} : $urandom;
      bad_at = spoil ? $urandom_range(31, 0) : -1;
      by_tick = 1'($urandom_range(1, 0));
      // time out any reception left over from noise
      while (rx_active) send_word(nec_ir_pkg::REQ_TICK, 16'($urandom), 1'b0, NO_KEY);
      edge_at_gap(window_gap(nec_ir_pkg::REG_LEAD_LOW, nec_ir_pkg::REG_LEAD_HIGH));
      for (i = 0; i < nec_ir_pkg::FRAME_BITS; i++) begin
         if (i == bad_at && by_tick)
            send_word(nec_ir_pkg::REQ_TICK, 16'($urandom), 1'b0, NO_KEY);
         if (i == bad_at && !by_tick)
            edge_at_gap(32'($urandom_range(9000, 2600)));
         else if (bits[i])
            edge_at_gap(window_gap(nec_ir_pkg::REG_ONE_LOW, nec_ir_pkg::REG_ONE_HIGH));
         else
            edge_at_gap(window_gap(nec_ir_pkg::REG_ZERO_LOW, nec_ir_pkg::REG_ZERO_HIGH));
         if ($urandom_range(23, 0) == 0)
            send_word(nec_ir_pkg::REQ_READ, 16'($urandom), 1'b0, NO_KEY);
      end
      send_word(nec_ir_pkg::REQ_READ, 16'($urandom), 1'b0, NO_KEY);
   endtask

   task automatic program_windows(input nec_ir_pkg::reg_file_type vals);
      int i;
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      for (i = 0; i < nec_ir_pkg::NUM_REGS; i++) begin
         csr_write_en <= 1'b1;
         csr_index <= nec_ir_pkg::reg_index_type'(i);
         csr_data <= vals[i];
         @(posedge clock);
         win[i] = vals[i];
      end
      csr_write_en <= 1'b0;
   endtask

   task automatic run_phase(input int word_quota, input int read_quota);
      int word_start;
      int read_start;
      int pick;
      int k;
      word_start = sent_count;
      read_start = read_count;
      while (sent_count - word_start < word_quota || read_count - read_start < read_quota) begin
         pick = $urandom_range(99, 0);
         if (pick < 50) begin
            send_frame($urandom_range(7, 0) == 0);
         end else if (pick < 62) begin
            edge_at_gap(window_gap(nec_ir_pkg::REG_REPEAT_LOW, nec_ir_pkg::REG_REPEAT_HIGH));
            if ($urandom_range(1, 0))
               send_word(nec_ir_pkg::REQ_READ, 16'($urandom), 1'b0, NO_KEY);
         end else if (pick < 72) begin
            k = $urandom_range(4, 1);
            repeat (k) send_word(2'($urandom), 16'($urandom), 1'b0, NO_KEY);
         end else if (pick < 80) begin
            // probe a window bound or one tick either side of it
            k = $urandom_range(nec_ir_pkg::NUM_REGS - 1, 0);
            edge_at_gap(32'(win[k]) + 32'($urandom_range(2, 0)) - 32'd1);
         end else if (pick < 95 || quiet_tail) begin
            send_word(nec_ir_pkg::REQ_READ, 16'($urandom), 1'b0, NO_KEY);
         end else begin
            req_valid <= 1'b0;
            while (pending_reports.size() != 0) @(posedge clock);
         end
      end
   endtask

   always @(posedge clock) begin
      if (quiet_tail || stall_left == 0) begin
         rsp_ready <= 1'b1;
         if (!quiet_tail && $urandom_range(11, 0) == 0) stall_left <= $urandom_range(13, 1);
      end else begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end
   end

   always @(posedge clock) begin
      key_report_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_reports.size() == 0) begin
            if (mismatch_count < 10)
               $display("unexpected key word: valid %0d code %02h frame %08h",
                        rsp_key_valid, rsp_key_code, rsp_frame_word);
            mismatch_count++;
         end else begin
            want = pending_reports.pop_front();
            if (rsp_key_valid !== want.key_valid || rsp_key_code !== want.key_code ||
                rsp_frame_word !== want.frame_word) begin
               if (mismatch_count < 10)
                  $display("key word %0d: expected %0d/%02h/%08h, got %0d/%02h/%08h",
                           key_words_seen, want.key_valid, want.key_code, want.frame_word,
                           rsp_key_valid, rsp_key_code, rsp_frame_word);
               mismatch_count++;
            end
         end
         key_words_seen++;
      end
   end

   initial begin
      #3000000;
      $display("Mismatches found");
      $finish;
   end

   initial begin
      nec_ir_pkg::reg_file_type shifted;
      int r;
      reset = 1'b1;
      req_valid = 1'b0;
      req_type = nec_ir_pkg::REQ_TICK;
      req_capture_value = '0;
      csr_write_en = 1'b0;
      csr_index = nec_ir_pkg::REG_LEAD_LOW;
      csr_data = '0;
      win = '{16'd13000, 16'd14000, 16'd11000, 16'd12000, 16'd2000, 16'd2500, 16'd1000, 16'd1300};
      rx_active = 1'b0;
      rx_bits = '0;
      prev_stamp = '0;
      ovf_cnt = '0;
      rx_word = '0;
      frame_pending = 1'b0;
      repeat_pending = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      for (r = 0; r < 23; r++)
         send_word(dir_plan[r].kind, dir_plan[r].cap, dir_plan[r].typed, dir_plan[r].rpt);

      run_phase(55, 3);
      // sender holds off until the result side is empty
      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);

      shifted[nec_ir_pkg::REG_ZERO_LOW] = 16'($urandom_range(1500, 500));
      shifted[nec_ir_pkg::REG_ZERO_HIGH] =
         shifted[nec_ir_pkg::REG_ZERO_LOW] + 16'($urandom_range(600, 2));
      shifted[nec_ir_pkg::REG_ONE_LOW] =
         shifted[nec_ir_pkg::REG_ZERO_HIGH] + 16'($urandom_range(500, 0));
      shifted[nec_ir_pkg::REG_ONE_HIGH] =
         shifted[nec_ir_pkg::REG_ONE_LOW] + 16'($urandom_range(800, 2));
      shifted[nec_ir_pkg::REG_REPEAT_LOW] = 16'($urandom_range(10000, 6000));
      shifted[nec_ir_pkg::REG_REPEAT_HIGH] =
         shifted[nec_ir_pkg::REG_REPEAT_LOW] + 16'($urandom_range(2000, 2));
      shifted[nec_ir_pkg::REG_LEAD_LOW] =
         shifted[nec_ir_pkg::REG_REPEAT_HIGH] + 16'($urandom_range(1000, 0));
      shifted[nec_ir_pkg::REG_LEAD_HIGH] =
         shifted[nec_ir_pkg::REG_LEAD_LOW] + 16'($urandom_range(3000, 2));
      program_windows(shifted);
      run_phase(75, 3);

      // overlapping windows: leader wins over repeat, one over zero
      program_windows('{16'd11000, 16'd14000, 16'd11000, 16'd12000,
                        16'd1000, 16'd2500, 16'd1000, 16'd1300});
      run_phase(65, 3);

      program_windows('{16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF});
      run_phase(45, 3);

      // empty windows: nothing can be decoded
      program_windows('{16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd0});
      run_phase(30, 3);

      program_windows('{16'd13000, 16'd14000, 16'd11000, 16'd12000,
                        16'd2000, 16'd2500, 16'd1000, 16'd1300});
      quiet_tail = 1'b1;
      run_phase(55, 3);

      req_valid <= 1'b0;
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      @(negedge clock);
      if (mismatch_count == 0) $display("No mismatches found");
      else $display("Mismatches found");
      $finish;
   end

endmodule
